FILE: hdl/tlex_pkg.sv
`default_nettype none

package tlex_pkg;

    localparam int DefLineBits    = 16;
    localparam int DefColumnBits  = 12;
    localparam int DefMaxHexDigits = 6;

    localparam int OutLineBits   = 16;
    localparam int OutColumnBits = 12;
    localparam int MaxResults    = 4;
    localparam int CountBits     = 3;

    localparam logic [2:0] KIND_WORD    = 3'd0;
    localparam logic [2:0] KIND_STRING  = 3'd1;
    localparam logic [2:0] KIND_PUNCT   = 3'd2;
    localparam logic [2:0] KIND_INVALID = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_ESCAPE = 3'd1;
    localparam logic [2:0] ERR_EOF_STRING = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
    localparam logic [2:0] ERR_HEX_LONG   = 3'd4;
    localparam logic [2:0] ERR_EOF_HEX    = 3'd5;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_ESCAPE    = 8'h1B;

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_COMMENT = 6'b000010,
        MODE_WORD    = 6'b000100,
        MODE_STRING  = 6'b001000,
        MODE_ESC     = 6'b010000,
        MODE_HEX     = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [7:0]               out_byte;
        logic                     is_content;
        logic [2:0]               token_kind;
        logic [2:0]               error_code;
        logic [OutLineBits-1:0]   origin_line;
        logic [OutColumnBits-1:0] start_column;
    } result_t;

    typedef result_t [MaxResults-1:0] result_set_t;

endpackage

`default_nettype wire

FILE: hdl/tlex_core.sv
`default_nettype none

module tlex_core
    import tlex_pkg::*;
#(
    parameter int LINE_BITS      = DefLineBits,
    parameter int COLUMN_BITS    = DefColumnBits,
    parameter int MAX_HEX_DIGITS = DefMaxHexDigits
)
(
    input  wire logic [7:0]                            in_byte,
    input  wire logic                                  end_of_input,
    input  wire mode_t                                 mode,
    input  wire logic [4*MAX_HEX_DIGITS-1:0]           hex_value,
    input  wire logic [$clog2(MAX_HEX_DIGITS+1)-1:0]   hex_digits,
    input  wire logic [LINE_BITS-1:0]                  line_count,
    input  wire logic [COLUMN_BITS-1:0]                column_count,
    input  wire logic [LINE_BITS-1:0]                  token_line,
    input  wire logic [COLUMN_BITS-1:0]                token_column,
    output mode_t                                      mode_next,
    output logic [4*MAX_HEX_DIGITS-1:0]                hex_value_next,
    output logic [$clog2(MAX_HEX_DIGITS+1)-1:0]        hex_digits_next,
    output logic [LINE_BITS-1:0]                       line_count_next,
    output logic [COLUMN_BITS-1:0]                     column_count_next,
    output logic [LINE_BITS-1:0]                       token_line_next,
    output logic [COLUMN_BITS-1:0]                     token_column_next,
    output result_set_t                                results,
    output logic [CountBits-1:0]                       result_count
);

    localparam int HexBits = 4 * MAX_HEX_DIGITS;
    localparam int DigBits = $clog2(MAX_HEX_DIGITS + 1);

    function automatic logic [OutLineBits-1:0] sat_line(input logic [LINE_BITS-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        return (ext > 32'h0000_FFFF) ? '1 : ext[OutLineBits-1:0];
    endfunction

    function automatic logic [OutColumnBits-1:0] sat_col(input logic [COLUMN_BITS-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        return (ext > 32'h0000_0FFF) ? '1 : ext[OutColumnBits-1:0];
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b == 8'h28) || (b == 8'h29) || (b == 8'h5B) || (b == 8'h5D) ||
               (b == 8'h7B) || (b == 8'h7D) || (b == CH_SEMI);
    endfunction

    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            d = b - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (b >= 8'h61 && b <= 8'h66)
        begin
            d = b - 8'h57;
            return {1'b1, d[3:0]};
        end
        if (b >= 8'h41 && b <= 8'h46)
        begin
            d = b - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic result_t mk(input logic [7:0] b, input logic content,
                                   input logic [2:0] kind, input logic [2:0] err,
                                   input logic [LINE_BITS-1:0] ln,
                                   input logic [COLUMN_BITS-1:0] col);
        result_t r;
        r.out_byte     = b;
        r.is_content   = content;
        r.token_kind   = kind;
        r.error_code   = err;
        r.origin_line  = sat_line(ln);
        r.start_column = sat_col(col);
        return r;
    endfunction

    logic [CountBits-1:0] n;
    logic                 do_idle;
    logic [4:0]           hd;
    logic [31:0]          v32;
    logic [20:0]          code;
    logic [7:0]           esc_val;
    logic                 esc_ok;

    always_comb
    begin
        mode_next         = mode;
        hex_value_next    = hex_value;
        hex_digits_next   = hex_digits;
        line_count_next   = line_count;
        column_count_next = column_count;
        token_line_next   = token_line;
        token_column_next = token_column;
        results           = '0;
        n                 = '0;
        do_idle           = 1'b0;
        hd                = hex_digit(in_byte);
        v32               = 32'(hex_value);
        code              = (v32 > 32'h0010_FFFF) ? 21'h00FFFD : v32[20:0];
        esc_ok            = 1'b1;
        unique case (in_byte)
            8'h74:        esc_val = 8'h09;
            8'h6E:        esc_val = 8'h0A;
            8'h72:        esc_val = 8'h0D;
            8'h62:        esc_val = 8'h08;
            8'h76:        esc_val = 8'h0B;
            8'h66:        esc_val = 8'h0C;
            8'h30:        esc_val = 8'h00;
            8'h65:        esc_val = CH_ESCAPE;
            CH_BACKSLASH: esc_val = CH_BACKSLASH;
            CH_QUOTE:     esc_val = CH_QUOTE;
            default:
            begin
                esc_val = 8'h00;
                esc_ok  = 1'b0;
            end
        endcase

        if (end_of_input)
        begin
            unique case (mode) inside
                MODE_WORD:
                begin
                    results[n[1:0]] = mk(8'h00, 1'b0, KIND_WORD, ERR_NONE,
                                         token_line, token_column);
                    n = n + 1'b1;
                end
                MODE_STRING, MODE_ESC:
                begin
                    results[n[1:0]] = mk(8'h00, 1'b0, KIND_INVALID, ERR_EOF_STRING,
                                         token_line, token_column);
                    n = n + 1'b1;
                end
                MODE_HEX:
                begin
                    results[n[1:0]] = mk(8'h00, 1'b0, KIND_INVALID, ERR_EOF_HEX,
                                         token_line, token_column);
                    n = n + 1'b1;
                end
                default:
                begin
                end
            endcase
            results[n[1:0]] = mk(8'h00, 1'b0, KIND_END, ERR_NONE, line_count, column_count);
            n = n + 1'b1;
            mode_next         = MODE_IDLE;
            hex_value_next    = '0;
            hex_digits_next   = '0;
            line_count_next   = '0;
            column_count_next = '0;
            token_line_next   = '0;
            token_column_next = '0;
        end
        else
        begin
            if (in_byte == CH_NEWLINE)
            begin
                if (!(&line_count))
                    line_count_next = line_count + 1'b1;
                column_count_next = '0;
            end
            else if (!(&column_count))
            begin
                column_count_next = column_count + 1'b1;
            end

            unique case (mode)
                MODE_IDLE:
                    do_idle = 1'b1;
                MODE_COMMENT:
                begin
                    if (in_byte == CH_NEWLINE)
                        mode_next = MODE_IDLE;
                end
                MODE_WORD:
                begin
                    if (is_ws(in_byte) || is_punct(in_byte) || in_byte == CH_BACKSLASH ||
                        in_byte == CH_QUOTE)
                    begin
                        results[n[1:0]] = mk(8'h00, 1'b0, KIND_WORD, ERR_NONE,
                                             token_line, token_column);
                        n = n + 1'b1;
                        mode_next = MODE_IDLE;
                        do_idle   = 1'b1;
                    end
                    else
                    begin
                        results[n[1:0]] = mk(in_byte, 1'b1, KIND_WORD, ERR_NONE,
                                             token_line, token_column);
                        n = n + 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (in_byte == CH_BACKSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else if (in_byte == CH_QUOTE)
                    begin
                        results[n[1:0]] = mk(8'h00, 1'b0, KIND_STRING, ERR_NONE,
                                             token_line, token_column);
                        n = n + 1'b1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        results[n[1:0]] = mk(in_byte, 1'b1, KIND_STRING, ERR_NONE,
                                             token_line, token_column);
                        n = n + 1'b1;
                    end
                end
                MODE_ESC:
                begin
                    if (esc_ok)
                    begin
                        results[n[1:0]] = mk(esc_val, 1'b1, KIND_STRING, ERR_NONE,
                                             token_line, token_column);
                        n = n + 1'b1;
                        mode_next = MODE_STRING;
                    end
                    else if (in_byte == 8'h78)
                    begin
                        hex_value_next  = '0;
                        hex_digits_next = '0;
                        mode_next       = MODE_HEX;
                    end
                    else
                    begin
                        results[n[1:0]] = mk(8'h00, 1'b0, KIND_INVALID, ERR_BAD_ESCAPE,
                                             token_line, token_column);
                        n = n + 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_HEX:
                begin
                    if (in_byte == CH_SEMI)
                    begin
                        // raw byte, then 2, 3 or 4 byte utf-8
                        if (v32 < 32'd256)
                        begin
                            results[0] = mk(v32[7:0], 1'b1, KIND_STRING, ERR_NONE,
                                            token_line, token_column);
                            n = 3'd1;
                        end
                        else if (code < 21'h000800)
                        begin
                            results[0] = mk({3'b110, code[10:6]}, 1'b1, KIND_STRING,
                                            ERR_NONE, token_line, token_column);
                            results[1] = mk({2'b10, code[5:0]}, 1'b1, KIND_STRING,
                                            ERR_NONE, token_line, token_column);
                            n = 3'd2;
                        end
                        else if (code < 21'h010000)
                        begin
                            results[0] = mk({4'b1110, code[15:12]}, 1'b1, KIND_STRING,
                                            ERR_NONE, token_line, token_column);
                            results[1] = mk({2'b10, code[11:6]}, 1'b1, KIND_STRING,
                                            ERR_NONE, token_line, token_column);
                            results[2] = mk({2'b10, code[5:0]}, 1'b1, KIND_STRING,
                                            ERR_NONE, token_line, token_column);
                            n = 3'd3;
                        end
                        else
                        begin
                            results[0] = mk({5'b11110, code[20:18]}, 1'b1, KIND_STRING,
                                            ERR_NONE, token_line, token_column);
                            results[1] = mk({2'b10, code[17:12]}, 1'b1, KIND_STRING,
                                            ERR_NONE, token_line, token_column);
                            results[2] = mk({2'b10, code[11:6]}, 1'b1, KIND_STRING,
                                            ERR_NONE, token_line, token_column);
                            results[3] = mk({2'b10, code[5:0]}, 1'b1, KIND_STRING,
                                            ERR_NONE, token_line, token_column);
                            n = 3'd4;
                        end
                        hex_value_next  = '0;
                        hex_digits_next = '0;
                        mode_next       = MODE_STRING;
                    end
                    else if (!hd[4])
                    begin
                        results[n[1:0]] = mk(8'h00, 1'b0, KIND_INVALID, ERR_BAD_HEX,
                                             token_line, token_column);
                        n = n + 1'b1;
                        mode_next = MODE_IDLE;
                    end
                    else if (hex_digits >= DigBits'(MAX_HEX_DIGITS))
                    begin
                        results[n[1:0]] = mk(8'h00, 1'b0, KIND_INVALID, ERR_HEX_LONG,
                                             token_line, token_column);
                        n = n + 1'b1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        hex_value_next  = HexBits'({hex_value, hd[3:0]});
                        hex_digits_next = hex_digits + 1'b1;
                    end
                end
                default:
                    mode_next = MODE_IDLE;
            endcase

            if (do_idle && !is_ws(in_byte))
            begin
                if (in_byte == CH_BACKSLASH)
                begin
                    mode_next = MODE_COMMENT;
                end
                else if (is_punct(in_byte))
                begin
                    results[n[1:0]] = mk(in_byte, 1'b0, KIND_PUNCT, ERR_NONE,
                                         line_count, column_count);
                    n = n + 1'b1;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    mode_next         = MODE_STRING;
                    token_line_next   = line_count;
                    token_column_next = column_count;
                end
                else
                begin
                    mode_next         = MODE_WORD;
                    token_line_next   = line_count;
                    token_column_next = column_count;
                    results[n[1:0]] = mk(in_byte, 1'b1, KIND_WORD, ERR_NONE,
                                         line_count, column_count);
                    n = n + 1'b1;
                end
            end
        end
        result_count = n;
    end

endmodule

`default_nettype wire

FILE: hdl/token_lexer.sv
// first result of a word is valid in the cycle after the word is taken
// throughput: one input word per cycle while each word yields at most one result
// and the output is not stalled; a word yielding several results (up to four) holds
// the input until its last result leaves, one result per cycle while not stalled
// reset: asynchronous, active low; lexer returns to idle at line 0, column 0
`default_nettype none

module token_lexer
    import tlex_pkg::*;
#(
    parameter int LINE_BITS      = DefLineBits,
    parameter int COLUMN_BITS    = DefColumnBits,
    parameter int MAX_HEX_DIGITS = DefMaxHexDigits
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_input,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             is_content,
    output logic [2:0]       token_kind,
    output logic [2:0]       error_code,
    output logic [15:0]      origin_line,
    output logic [11:0]      start_column,
    output logic             last_result
);

    localparam int HexBits = 4 * MAX_HEX_DIGITS;
    localparam int DigBits = $clog2(MAX_HEX_DIGITS + 1);

    mode_t                    mode_reg, mode_next;
    logic [HexBits-1:0]       hex_value_reg, hex_value_next;
    logic [DigBits-1:0]       hex_digits_reg, hex_digits_next;
    logic [LINE_BITS-1:0]     line_count_reg, line_count_next;
    logic [COLUMN_BITS-1:0]   column_count_reg, column_count_next;
    logic [LINE_BITS-1:0]     token_line_reg, token_line_next;
    logic [COLUMN_BITS-1:0]   token_column_reg, token_column_next;

    result_set_t              results_reg, results_next;
    logic [CountBits-1:0]     count_reg, count_next;
    logic [CountBits-1:0]     index_reg;

    result_t                  cur;
    logic                     in_take;
    logic                     out_take;
    logic                     at_last;

    tlex_core #(
        .LINE_BITS      (LINE_BITS),
        .COLUMN_BITS    (COLUMN_BITS),
        .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
    ) u_core (
        .in_byte           (in_byte),
        .end_of_input      (end_of_input),
        .mode              (mode_reg),
        .hex_value         (hex_value_reg),
        .hex_digits        (hex_digits_reg),
        .line_count        (line_count_reg),
        .column_count      (column_count_reg),
        .token_line        (token_line_reg),
        .token_column      (token_column_reg),
        .mode_next         (mode_next),
        .hex_value_next    (hex_value_next),
        .hex_digits_next   (hex_digits_next),
        .line_count_next   (line_count_next),
        .column_count_next (column_count_next),
        .token_line_next   (token_line_next),
        .token_column_next (token_column_next),
        .results           (results_next),
        .result_count      (count_next)
    );

    // result buffer drains in order, next word may enter as the last entry leaves
    assign out_valid = (index_reg != count_reg);
    assign at_last   = (index_reg == count_reg - 1'b1);
    assign in_stall  = out_valid && !(at_last && !out_stall);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;

    assign cur          = results_reg[index_reg[1:0]];
    assign out_byte     = cur.out_byte;
    assign is_content   = cur.is_content;
    assign token_kind   = cur.token_kind;
    assign error_code   = cur.error_code;
    assign origin_line  = cur.origin_line;
    assign start_column = cur.start_column;
    assign last_result  = at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            hex_value_reg    <= '0;
            hex_digits_reg   <= '0;
            line_count_reg   <= '0;
            column_count_reg <= '0;
            token_line_reg   <= '0;
            token_column_reg <= '0;
            count_reg        <= '0;
            index_reg        <= '0;
        end
        else if (in_take)
        begin
            mode_reg         <= mode_next;
            hex_value_reg    <= hex_value_next;
            hex_digits_reg   <= hex_digits_next;
            line_count_reg   <= line_count_next;
            column_count_reg <= column_count_next;
            token_line_reg   <= token_line_next;
            token_column_reg <= token_column_next;
            count_reg        <= count_next;
            index_reg        <= '0;
        end
        else if (out_take)
        begin
            index_reg <= index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            results_reg <= results_next;
    end

endmodule

`default_nettype wire

FILE: tb/tb_token_lexer.sv
`default_nettype none

module tb_token_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    import tlex_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEM_COUNT = 430;
    localparam logic [15:0] LINE_MAX = 16'((1 << DefLineBits) - 1);
    localparam logic [11:0] COLUMN_MAX = 12'((1 << DefColumnBits) - 1);

    typedef struct packed {
        result_t rec;
        logic    last;
    } lex_record_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic end_of_input = 1'b0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic [7:0] out_byte;
    logic is_content;
    logic [2:0] token_kind;
    logic [2:0] error_code;
    logic [15:0] origin_line;
    logic [11:0] start_column;
    logic last_result;

    // lexer state as the stream is seen from outside
    mode_t lx_mode = MODE_IDLE;
    logic [31:0] hex_acc = '0;
    int hex_count = 0;
    logic [15:0] cur_line = '0;
    logic [11:0] cur_col = '0;
    logic [15:0] tok_line = '0;
    logic [11:0] tok_col = '0;

    lex_record_t lexer_records[$];
    lex_record_t head_record;
    int mismatches = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    logic tx_gaps = 1'b1;
    logic rx_gaps = 1'b1;
    logic rx_hold = 1'b0;
    event hold_off;

    token_lexer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .is_content   (is_content),
        .token_kind   (token_kind),
        .error_code   (error_code),
        .origin_line  (origin_line),
        .start_column (start_column),
        .last_result  (last_result)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_punct(logic [7:0] b);
        return b == "(" || b == ")" || b == "[" || b == "]" || b == "{" ||
               b == "}" || b == CH_SEMI;
    endfunction

    function automatic int hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9")
            return int'(b) - 48;
        if (b >= "a" && b <= "f")
            return int'(b) - 87;
        if (b >= "A" && b <= "F")
            return int'(b) - 55;
        return -1;
    endfunction

    function automatic int escape_value(logic [7:0] b);
        case (b)
            "t":          return 9;
            "n":          return 10;
            "r":          return 13;
            "b":          return 8;
            "v":          return 11;
            "f":          return 12;
            "0":          return 0;
            "e":          return int'(CH_ESCAPE);
            CH_BACKSLASH: return int'(CH_BACKSLASH);
            CH_QUOTE:     return int'(CH_QUOTE);
            default:      return -1;
        endcase
    endfunction

    function automatic void add_record(logic [7:0] b, logic content, logic [2:0] kind,
                                       logic [2:0] err, logic [15:0] ln, logic [11:0] col);
        lex_record_t r;
        r.rec.out_byte = b;
        r.rec.is_content = content;
        r.rec.token_kind = kind;
        r.rec.error_code = err;
        r.rec.origin_line = ln;
        r.rec.start_column = col;
        r.last = 1'b0;
        lexer_records.push_back(r);
    endfunction

    function automatic void invalid_token(logic [2:0] err);
        add_record(8'h00, 1'b0, KIND_INVALID, err, tok_line, tok_col);
        lx_mode = MODE_IDLE;
    endfunction

    function automatic void string_byte(logic [7:0] b);
        add_record(b, 1'b1, KIND_STRING, ERR_NONE, tok_line, tok_col);
    endfunction

    function automatic void lex_between_tokens(logic [7:0] b, logic [15:0] pl,
                                               logic [11:0] pc);
        if (is_space(b))
            return;
        if (b == CH_BACKSLASH)
            lx_mode = MODE_COMMENT;
        else if (is_punct(b))
            add_record(b, 1'b0, KIND_PUNCT, ERR_NONE, pl, pc);
        else if (b == CH_QUOTE)
        begin
            lx_mode = MODE_STRING;
            tok_line = pl;
            tok_col = pc;
        end
        else
        begin
            lx_mode = MODE_WORD;
            tok_line = pl;
            tok_col = pc;
            add_record(b, 1'b1, KIND_WORD, ERR_NONE, pl, pc);
        end
    endfunction

    // code point to raw byte or utf-8, out of range becomes the replacement char
    function automatic void encode_code_point(logic [31:0] v);
        logic [31:0] c;
        c = (v > 32'h10FFFF) ? 32'hFFFD : v;
        if (v < 32'd256)
            string_byte(c[7:0]);
        else if (c < 32'h800)
        begin
            string_byte(8'hC0 | 8'(c >> 6));
            string_byte(8'h80 | 8'(c & 32'h3F));
        end
        else if (c < 32'h10000)
        begin
            string_byte(8'hE0 | 8'(c >> 12));
            string_byte(8'h80 | 8'((c >> 6) & 32'h3F));
            string_byte(8'h80 | 8'(c & 32'h3F));
        end
        else
        begin
            string_byte(8'hF0 | 8'(c >> 18));
            string_byte(8'h80 | 8'((c >> 12) & 32'h3F));
            string_byte(8'h80 | 8'((c >> 6) & 32'h3F));
            string_byte(8'h80 | 8'(c & 32'h3F));
        end
    endfunction

    function automatic void lex_byte(logic [7:0] b, logic eoi);
        int first;
        int v;
        int d;
        logic [15:0] pl;
        logic [11:0] pc;
        first = lexer_records.size();
        pl = cur_line;
        pc = cur_col;
        if (eoi)
        begin
            case (lx_mode)
                MODE_WORD:   add_record(8'h00, 1'b0, KIND_WORD, ERR_NONE, tok_line, tok_col);
                MODE_STRING: invalid_token(ERR_EOF_STRING);
                MODE_ESC:    invalid_token(ERR_EOF_STRING);
                MODE_HEX:    invalid_token(ERR_EOF_HEX);
                default:     ;
            endcase
            add_record(8'h00, 1'b0, KIND_END, ERR_NONE, cur_line, cur_col);
            lx_mode = MODE_IDLE;
            hex_acc = '0;
            hex_count = 0;
            cur_line = '0;
            cur_col = '0;
            tok_line = '0;
            tok_col = '0;
        end
        else
        begin
            if (b == CH_NEWLINE)
            begin
                if (cur_line != LINE_MAX)
                    cur_line = cur_line + 16'd1;
                cur_col = '0;
            end
            else if (cur_col != COLUMN_MAX)
                cur_col = cur_col + 12'd1;
            case (lx_mode)
                MODE_IDLE:
                    lex_between_tokens(b, pl, pc);
                MODE_COMMENT:
                    if (b == CH_NEWLINE)
                        lx_mode = MODE_IDLE;
                MODE_WORD:
                    if (is_space(b) || is_punct(b) || b == CH_BACKSLASH || b == CH_QUOTE)
                    begin
                        add_record(8'h00, 1'b0, KIND_WORD, ERR_NONE, tok_line, tok_col);
                        lx_mode = MODE_IDLE;
                        lex_between_tokens(b, pl, pc);
                    end
                    else
                        add_record(b, 1'b1, KIND_WORD, ERR_NONE, tok_line, tok_col);
                MODE_STRING:
                    if (b == CH_BACKSLASH)
                        lx_mode = MODE_ESC;
                    else if (b == CH_QUOTE)
                    begin
                        add_record(8'h00, 1'b0, KIND_STRING, ERR_NONE, tok_line, tok_col);
                        lx_mode = MODE_IDLE;
                    end
                    else
                        string_byte(b);
                MODE_ESC:
                begin
                    v = escape_value(b);
                    if (v >= 0)
                    begin
                        string_byte(8'(v));
                        lx_mode = MODE_STRING;
                    end
                    else if (b == "x")
                    begin
                        hex_acc = '0;
                        hex_count = 0;
                        lx_mode = MODE_HEX;
                    end
                    else
                        invalid_token(ERR_BAD_ESCAPE);
                end
                MODE_HEX:
                begin
                    d = hex_digit(b);
                    if (b == CH_SEMI)
                    begin
                        encode_code_point(hex_acc);
                        hex_acc = '0;
                        hex_count = 0;
                        lx_mode = MODE_STRING;
                    end
                    else if (d < 0)
                        invalid_token(ERR_BAD_HEX);
                    else if (hex_count >= DefMaxHexDigits)
                        invalid_token(ERR_HEX_LONG);
                    else
                    begin
                        hex_acc = {hex_acc[27:0], 4'(d)};
                        hex_count++;
                    end
                end
                default:
                    lx_mode = MODE_IDLE;
            endcase
        end
        if (lexer_records.size() > first)
            lexer_records[lexer_records.size() - 1].last = 1'b1;
    endfunction

    task automatic send_item(input logic [7:0] b, input logic eoi);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        lex_byte(b, eoi);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_hex_digits(input int n);
        int v;
        repeat (n)
        begin
            v = $urandom_range(0, 15);
            if (v < 10)
                send_byte(8'h30 + 8'(v));
            else
                send_byte(($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 10));
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (lexer_records.size() == 0)
                report_mismatch("record with none predicted", 32'(out_byte), 32'h0);
            else
            begin
                head_record = lexer_records.pop_front();
                check_field("out_byte", 32'(out_byte), 32'(head_record.rec.out_byte));
                check_field("is_content", 32'(is_content), 32'(head_record.rec.is_content));
                check_field("token_kind", 32'(token_kind), 32'(head_record.rec.token_kind));
                check_field("error_code", 32'(error_code), 32'(head_record.rec.error_code));
                check_field("origin_line", 32'(origin_line), 32'(head_record.rec.origin_line));
                check_field("start_column", 32'(start_column),
                            32'(head_record.rec.start_column));
                check_field("last_result", 32'(last_result), 32'(head_record.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (rx_gaps && $urandom_range(0, 3) == 0)
        begin
            stall_left <= pick_gap();
            out_stall <= 1'b1;
        end
        else
            out_stall <= rx_hold;
    end

    always @(hold_off)
    begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_token_lexer: FAIL");
            $finish;
        end
    end

    task automatic test_punctuation_and_words();
        send_text("(a)[bc]{d};e\\ c\nh\"s\"f\tg");
        send_end();
    endtask

    task automatic test_string_escapes();
        send_text("\"\\t\\n\\r\\b\\v\\f\\0\\e\\\\\\\"\"");
        send_end();
    endtask

    task automatic test_hex_escapes();
        send_text("\"\\x;\\xff;\\x7FF;\\xFFFF;\\x10FFFF;\\xFFFFFF;\"");
        send_end();
    endtask

    task automatic test_lexing_errors();
        send_text("\"\\q \"\\xg \"\\x1234567 \"\\x123456z");
        send_end();
    endtask

    task automatic test_end_of_input();
        send_text("ab");
        send_end();
        send_text("\"ab");
        send_end();
        send_text("\"\\");
        send_end();
        send_text("\"\\x1");
        send_end();
        send_text("\\ c");
        send_end();
        send_end();
    endtask

    task automatic test_byte_extremes();
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(CH_NEWLINE);
        send_byte(CH_QUOTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(CH_QUOTE);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_output_hold_off();
        tx_gaps = 1'b0;
        -> hold_off;
        send_text("\"\\x1F600;\\x1F600;\\x20AC;abc\" (x) [y]");
        send_end();
        tx_gaps = 1'b1;
    endtask

    task automatic test_random_source();
        string delims;
        string escapes;
        string puncts;
        string spaces;
        int stop;
        int r;
        int n;
        int k;
        logic [7:0] b;
        delims = " \n\t()[]{};";
        escapes = "tnrbvf0e\\\"";
        puncts = "()[]{};";
        spaces = " \t\n\013\014\015";
        stop = ITEM_COUNT;
        while (bytes_sent < stop)
        begin
            if ($urandom_range(0, 9) == 0)
                tx_gaps = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0)
                rx_gaps = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (is_space(b) || is_punct(b) || b == CH_BACKSLASH || b == CH_QUOTE);
                    send_byte(b);
                end
                if ($urandom_range(0, 3) != 0)
                    send_byte(delims[$urandom_range(0, delims.len() - 1)]);
            end
            else if (r < 50)
            begin
                send_byte(CH_QUOTE);
                n = $urandom_range(0, 5);
                repeat (n)
                begin
                    k = $urandom_range(0, 9);
                    if (k < 5)
                    begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == CH_BACKSLASH || b == CH_QUOTE);
                        send_byte(b);
                    end
                    else if (k < 8)
                    begin
                        send_byte(CH_BACKSLASH);
                        send_byte(escapes[$urandom_range(0, escapes.len() - 1)]);
                    end
                    else
                    begin
                        send_text("\\x");
                        send_hex_digits($urandom_range(0, DefMaxHexDigits));
                        send_byte(CH_SEMI);
                    end
                end
                send_byte(CH_QUOTE);
            end
            else if (r < 58)
                send_byte(puncts[$urandom_range(0, puncts.len() - 1)]);
            else if (r < 66)
                send_byte(spaces[$urandom_range(0, spaces.len() - 1)]);
            else if (r < 72)
            begin
                send_byte(CH_BACKSLASH);
                n = $urandom_range(0, 5);
                repeat (n)
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_NEWLINE);
                    send_byte(b);
                end
                send_byte(CH_NEWLINE);
            end
            else if (r < 84)
            begin
                // broken strings and escapes
                send_byte(CH_QUOTE);
                if ($urandom_range(0, 1))
                    send_byte(8'h41 + 8'($urandom_range(0, 25)));
                k = $urandom_range(0, 4);
                if (k == 0)
                begin
                    send_byte(CH_BACKSLASH);
                    do
                        b = 8'($urandom_range(0, 255));
                    while (escape_value(b) >= 0 || b == "x");
                    send_byte(b);
                end
                else if (k == 1)
                begin
                    send_text("\\x");
                    send_hex_digits($urandom_range(0, DefMaxHexDigits));
                    do
                        b = 8'($urandom_range(0, 255));
                    while (hex_digit(b) >= 0 || b == CH_SEMI);
                    send_byte(b);
                end
                else if (k == 2)
                begin
                    send_text("\\x");
                    send_hex_digits(DefMaxHexDigits + 1);
                end
                else if (k == 3)
                begin
                    send_text("\\x");
                    send_hex_digits($urandom_range(0, DefMaxHexDigits));
                    send_end();
                end
                else
                begin
                    if ($urandom_range(0, 1))
                        send_byte(CH_BACKSLASH);
                    send_end();
                end
            end
            else if (r < 90)
                send_end();
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        end
        send_end();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_punctuation_and_words();
        test_string_escapes();
        test_hex_escapes();
        test_lexing_errors();
        test_end_of_input();
        test_byte_extremes();
        test_output_hold_off();
        test_random_source();
        in_valid <= 1'b0;
        while (lexer_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_token_lexer: PASS");
        else
            $display("tb_token_lexer: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
